// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// simulation gets concurrent assertions, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bbd_pkg.sv =====
// types and constants for the button bank debouncer
// no dependencies
package bbd_pkg;

	localparam int MAX_BUTTONS = 16;
	localparam int RAW_W       = 16;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CNT_W-1:0] DEF_THRESHOLD = 4'd10;
	localparam logic [RAW_W-1:0] DEF_COMBO     = 16'h001C;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 1'b0,
		REG_COMBO     = 1'b1
	} cfg_reg_t;

	// event produced by one processed sample
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] button_index;
		logic             pressed;
		logic             combo_event;
	} evt_t;

endpackage

// ===== rtl/bbd_if.sv =====
// valid/ready channel interfaces for the button bank debouncer
// depends on bbd_pkg
interface bbd_in_if;
	logic                     valid;
	logic                     ready;
	logic [bbd_pkg::RAW_W-1:0] raw_levels;

	modport source (output valid, output raw_levels, input ready);
	modport sink (input valid, input raw_levels, output ready);
endinterface

interface bbd_out_if;
	logic                      valid;
	logic                      ready;
	logic [bbd_pkg::IDX_W-1:0] button_index;
	logic                      pressed;
	logic                      combo_event;

	modport source (output valid, output button_index, output pressed, output combo_event,
		input ready);
	modport sink (input valid, input button_index, input pressed, input combo_event,
		output ready);
endinterface

// ===== rtl/bbd_counter_bank.sv =====
// per-button saturating integrating counters and debounced flags
// depends on bbd_pkg
module bbd_counter_bank #(
	parameter int NUM_BUTTONS = bbd_pkg::MAX_BUTTONS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [NUM_BUTTONS-1:0]     held,
	input  logic [bbd_pkg::CNT_W-1:0]  threshold,
	output logic [NUM_BUTTONS-1:0]     flags_next
);
	import bbd_pkg::*;

	logic [CNT_W-1:0]       cnt_q [NUM_BUTTONS];
	logic [CNT_W-1:0]       cnt_next [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] flags_q;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			logic [CNT_W:0] inc;
			inc = {1'b0, cnt_q[i]} + (CNT_W+1)'(1);
			cnt_next[i]   = cnt_q[i];
			flags_next[i] = flags_q[i];
			if (held[i]) begin
				if (inc >= {1'b0, threshold}) begin
					cnt_next[i]   = threshold;
					flags_next[i] = 1'b1;
				end else begin
					cnt_next[i] = inc[CNT_W-1:0];
				end
			end else begin
				// count of one or zero drops to zero and releases
				if (cnt_q[i] <= CNT_W'(1)) begin
					cnt_next[i]   = '0;
					flags_next[i] = 1'b0;
				end else begin
					cnt_next[i] = cnt_q[i] - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (step) begin
			flags_q <= flags_next;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= cnt_next[i];
			end
		end
	end

endmodule

// ===== rtl/bbd_event_gen.sv =====
// change detection against the reported word, combo match and priority encoder
// depends on bbd_pkg
module bbd_event_gen #(
	parameter int NUM_BUTTONS = bbd_pkg::MAX_BUTTONS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [NUM_BUTTONS-1:0]    flags,
	input  logic [bbd_pkg::RAW_W-1:0] combo_pattern,
	output bbd_pkg::evt_t             evt
);
	import bbd_pkg::*;

	logic [NUM_BUTTONS-1:0] reported_q;
	logic [NUM_BUTTONS-1:0] diff;
	logic                   combo_hit;
	logic [IDX_W-1:0]       low_idx;

	assign diff      = reported_q ^ flags;
	assign combo_hit = (RAW_W'(flags) == combo_pattern);

	// lowest set bit of diff
	always_comb begin
		low_idx = '0;
		for (int i = NUM_BUTTONS-1; i >= 0; i--) begin
			if (diff[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		evt.valid        = (diff != '0);
		evt.combo_event  = combo_hit;
		evt.button_index = combo_hit ? '0 : low_idx;
		evt.pressed      = combo_hit ? 1'b0 : flags[low_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= '0;
		end else if (step && (diff != '0) && !combo_hit) begin
			reported_q <= flags;
		end
	end

endmodule

// ===== rtl/button_bank_debouncer_events.sv =====
// button bank debouncer with change events, top level
// a sample goes through the input register, then the result register, to the output
// throughput: one sample beat per cycle unless the sink stalls the result register
// reset: counters, debounced flags and reported word clear, threshold 10, combo 0x1C
// depends on bbd_pkg, bbd_if, bbd_counter_bank, bbd_event_gen, assert_macros.svh
`include "assert_macros.svh"

module button_bank_debouncer_events #(
	parameter int NUM_BUTTONS = bbd_pkg::MAX_BUTTONS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bbd_in_if.sink                         in_ch,
	bbd_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbd_pkg::*;

	// configuration registers
	logic [CNT_W-1:0] threshold_q;
	logic [RAW_W-1:0] combo_q;

	// input register stage
	logic             valid_s1;
	logic [RAW_W-1:0] raw_s1;

	// result register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;
	logic             out_pressed_q;
	logic             out_combo_q;

	logic                   step;
	logic [NUM_BUTTONS-1:0] flags_next;
	evt_t                   evt;

	// the sample in s1 is processed once the result register can take it,
	// whether or not it yields a result beat
	assign step        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= DEF_THRESHOLD;
			combo_q     <= DEF_COMBO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[CNT_W-1:0];
				REG_COMBO:     combo_q     <= cfg_data[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			raw_s1 <= in_ch.raw_levels;
		end
	end

	// pins are active low: a low level means held
	bbd_counter_bank #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.held       (~raw_s1[NUM_BUTTONS-1:0]),
		.threshold  (threshold_q),
		.flags_next (flags_next)
	);

	// event decision works on the freshly updated flags
	bbd_event_gen #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_events (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.flags         (flags_next),
		.combo_pattern (combo_q),
		.evt           (evt)
	);

	// result register, loaded on every processed sample, drained by the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= evt.valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_index_q   <= evt.button_index;
			out_pressed_q <= evt.pressed;
			out_combo_q   <= evt.combo_event;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.button_index = out_index_q;
	assign out_ch.pressed      = out_pressed_q;
	assign out_ch.combo_event  = out_combo_q;

	// a combo beat carries index zero and a released state
	`ASSERT_PROP(a_combo_payload, clk, arst_n, !(out_ch.valid && out_ch.combo_event) || (out_ch.button_index == '0 && !out_ch.pressed))
	// a full s1 behind a stalled result beat blocks the input
	`ASSERT_PROP(a_stall_blocks, clk, arst_n, !(valid_s1 && out_ch.valid && !out_ch.ready) || !in_ch.ready)
	// a stalled result beat stays valid on the next edge
	`ASSERT_NEXT(a_result_kept, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

endmodule

// ===== tb/button_bank_debouncer_events_tb.sv =====
// self-checking testbench for the button bank debouncer with change events
// drives sample beats, predicts the event beats and checks them in order
// depends on bbd_pkg, bbd_if and button_bank_debouncer_events
module button_bank_debouncer_events_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbd_pkg::*;

	// result register plus input register, with margin for an eventless beat in flight
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int BOUNCE_PCT   = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bbd_in_if  in_if();
	bbd_out_if out_if();

	button_bank_debouncer_events uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// samples waiting to go out and events the block still owes us
	logic [RAW_W-1:0] pending_raw [$];
	evt_t             expected_events [$];

	// idling knobs, percent of cycles
	int send_idle_pct;
	int recv_stall_pct;

	int mismatches;
	int cycle_cnt;

	// debouncer state as the block should hold it
	logic [CNT_W-1:0] hold_cnt [MAX_BUTTONS];
	logic [RAW_W-1:0] db_flags;
	logic [RAW_W-1:0] rep_mask;
	logic [CNT_W-1:0] thr_cfg;
	logic [RAW_W-1:0] combo_cfg;

	// one sample tick: move every integrator, then decide on the event
	function automatic void debounce_sample(input logic [RAW_W-1:0] raw);
		int               cnt;
		evt_t             ev;
		logic [RAW_W-1:0] diff;
		for (int i = 0; i < MAX_BUTTONS; i++) begin
			cnt = int'(hold_cnt[i]);
			if (!raw[i]) begin
				// pin low, button held: count up, saturate at threshold
				cnt++;
				if (cnt >= int'(thr_cfg)) begin
					cnt = int'(thr_cfg);
					db_flags[i] = 1'b1;
				end
			end else begin
				// pin high: count down, saturate at zero
				cnt--;
				if (cnt <= 0) begin
					cnt = 0;
					db_flags[i] = 1'b0;
				end
			end
			hold_cnt[i] = cnt[CNT_W-1:0];
		end
		diff = rep_mask ^ db_flags;
		// nothing new to report, even if the word matches the combo
		if (diff == '0)
			return;
		ev = '0;
		ev.valid = 1'b1;
		if (db_flags == combo_cfg) begin
			// combo beat repeats every tick, reported word is held
			ev.combo_event = 1'b1;
		end else begin
			// walk down so the lowest changed button wins
			for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
				if (diff[i]) begin
					ev.button_index = IDX_W'(i);
					ev.pressed      = db_flags[i];
				end
			end
			rep_mask = db_flags;
		end
		expected_events.push_back(ev);
	endfunction

	task automatic report_mismatch(input string what, input evt_t got, input evt_t want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch (%0s) at cycle %0d: got idx %0d prs %0b combo %0b, want idx %0d prs %0b combo %0b",
				what, cycle_cnt, got.button_index, got.pressed, got.combo_event,
				want.button_index, want.pressed, want.combo_event);
	endtask

	// queue a run of ticks holding the given buttons, with occasional contact bounce
	function automatic void queue_hold(input logic [RAW_W-1:0] mask, input int ticks);
		logic [RAW_W-1:0] raw;
		repeat (ticks) begin
			raw = ~mask;
			if ($urandom_range(99) < BOUNCE_PCT)
				raw ^= RAW_W'(1) << $urandom_range(RAW_W - 1);
			pending_raw.push_back(raw);
		end
	endfunction

	// mostly presses and releases that settle, some short glitches and raw noise
	function automatic void queue_random(input int n);
		int               added;
		int               pick;
		int               len;
		logic [RAW_W-1:0] target;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(99);
			if (pick < 25)
				target = combo_cfg;
			else if (pick < 35)
				target = '0;
			else if (pick < 45)
				target = '1;
			else if (pick < 60)
				target = RAW_W'(1) << $urandom_range(RAW_W - 1);
			else if (pick < 80)
				target = RAW_W'($urandom & $urandom);
			else
				target = RAW_W'($urandom);
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, 3);
			else
				len = int'(thr_cfg) + $urandom_range(0, 4);
			if (len < 1)
				len = 1;
			if (pick >= 92) begin
				// pure noise on every pin
				repeat (len)
					pending_raw.push_back(RAW_W'($urandom));
			end else begin
				queue_hold(target, len);
			end
			added += len;
		end
	endfunction

	// block is idle once nothing is queued, sent or owed, plus the pipeline depth
	task automatic wait_drained();
		while (pending_raw.size() != 0 || in_if.valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back; threshold data carries junk in the upper bits
	task automatic set_config(input logic [CNT_W-1:0] thr, input logic [RAW_W-1:0] combo);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data  <= {12'($urandom), thr};
		@(posedge clk);
		cfg_index <= REG_COMBO;
		cfg_data  <= combo;
		@(posedge clk);
		cfg_we    <= 1'b0;
		thr_cfg   = thr;
		combo_cfg = combo;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("button_bank_debouncer_events regression: fail");
			$finish;
		end
	end

	// sample beat driver: a new beat only when the last one was taken or none was up
	always @(posedge clk) begin
		if (arst_n && (!in_if.valid || in_if.ready)) begin
			if (pending_raw.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_if.valid      <= 1'b1;
				in_if.raw_levels <= pending_raw.pop_front();
			end else begin
				in_if.valid      <= 1'b0;
				in_if.raw_levels <= RAW_W'($urandom);
			end
		end
	end

	// receiver stalls, event beat checks, and prediction on every accepted sample beat
	always @(posedge clk) begin
		evt_t got;
		evt_t want;
		if (arst_n) begin
			out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_if.valid && out_if.ready) begin
				got = '0;
				got.valid        = 1'b1;
				got.button_index = out_if.button_index;
				got.pressed      = out_if.pressed;
				got.combo_event  = out_if.combo_event;
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected beat", got, '0);
				end else begin
					want = expected_events.pop_front();
					if (got.button_index !== want.button_index)
						report_mismatch("button_index", got, want);
					if (got.pressed !== want.pressed)
						report_mismatch("pressed", got, want);
					if (got.combo_event !== want.combo_event)
						report_mismatch("combo_event", got, want);
				end
			end
			// this beat's event still has to pass the input and result registers, so it cannot be checked above
			if (in_if.valid && in_if.ready)
				debounce_sample(in_if.raw_levels);
		end
	end

	// stimulus sequencer
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_THRESHOLD;
		cfg_data         = '0;
		in_if.valid      = 1'b0;
		in_if.raw_levels = '1;
		out_if.ready     = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		mismatches       = 0;
		cycle_cnt        = 0;
		for (int i = 0; i < MAX_BUTTONS; i++)
			hold_cnt[i] = '0;
		db_flags  = '0;
		rep_mask  = '0;
		thr_cfg   = DEF_THRESHOLD;
		combo_cfg = DEF_COMBO;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers as they come up, no idling
		// all released is quiet, then buttons 2..4 settle together into the default combo
		pending_raw.push_back('1);
		pending_raw.push_back('1);
		queue_hold(16'h001C, 0);
		repeat (11) pending_raw.push_back(~16'h001C);
		// one released tick only nudges the counters, combo keeps firing
		pending_raw.push_back('1);
		queue_random(60);

		// threshold 1 drops any higher counters back on the next held tick
		wait_drained();
		set_config(4'd1, 16'hAAAA);
		send_idle_pct  = 85;
		recv_stall_pct = 0;
		pending_raw.push_back('1);
		pending_raw.push_back('0);
		pending_raw.push_back('1);
		pending_raw.push_back(16'h5555);
		pending_raw.push_back(16'h5555);
		pending_raw.push_back(16'h7FFF);
		pending_raw.push_back('1);
		queue_random(70);

		// slowest threshold, combo is every button held
		wait_drained();
		set_config(4'd15, 16'hFFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 85;
		queue_random(70);

		// threshold zero: flags follow the pins directly, combo is the all-released word
		wait_drained();
		set_config(4'd0, 16'h0000);
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		pending_raw.push_back(16'hFFFE);
		pending_raw.push_back('1);
		pending_raw.push_back('0);
		pending_raw.push_back('1);
		queue_random(60);

		// random setting under mixed idling
		wait_drained();
		set_config(4'($urandom_range(1, 15)), RAW_W'($urandom));
		queue_random(70);

		// short threshold, corner buttons as combo, full rate
		wait_drained();
		set_config(4'd3, 16'h8001);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(70);

		wait_drained();
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("button_bank_debouncer_events regression: pass");
		end else begin
			$display("button_bank_debouncer_events regression: fail");
		end
		$finish;
	end

endmodule
